@@ rtl/glep_pkg.sv @@
package glep_pkg;

   // command codes
   localparam logic [1:0] CMD_WRITE   = 2'd0;
   localparam logic [1:0] CMD_BAKE    = 2'd1;
   localparam logic [1:0] CMD_TICK    = 2'd2;
   localparam logic [1:0] CMD_RETRIG  = 2'd3;

   // register map
   localparam int          CSR_AW            = 3;
   localparam logic [2:0]  ADDR_ENV_LENGTH    = 3'h0;
   localparam logic [2:0]  ADDR_CHANNEL_COUNT = 3'h4;
   localparam logic        REG_ENV_LENGTH     = 1'b0;
   localparam logic        REG_CHANNEL_COUNT  = 1'b1;

   localparam logic [15:0] ENV_LENGTH_RESET    = 16'd4096;
   localparam logic [1:0]  CHANNEL_COUNT_RESET = 2'd2;

   // envelope
   localparam int          POS_W   = 17;
   localparam logic [16:0] POS_MAX = 17'h1FFFF;
   localparam int          VOL_W   = 16;
   localparam int          Q15_SH  = 15;

   // shared divider
   localparam int DVD_W     = 32;
   localparam int DVS_W     = 16;
   localparam int CNT_W     = 6;
   localparam int VOL_STEPS = 31;

   // field widths
   localparam int SVAL_W  = 16;
   localparam int SIDX_W  = 13;
   localparam int WST_W   = 12;
   localparam int WEND_W  = 13;
   localparam int SPAN_W  = 14;
   localparam int LCNT_W  = 13;
   localparam int AUDIO_W = 16;

endpackage

@@ rtl/grain_loop_bake_and_envelope_player.sv @@
// grain loop bake and envelope player
//
// command channel: an item is taken on a rising edge with start high and busy
// low. req_cmd selects write sample, bake window, output tick or retrigger.
// every item returns one word on the rsp_ ports, marked by rsp_strobe for a
// single cycle; the receiver cannot stall, so the word must be taken then.
// busy stays high from the accepting edge until the word is presented.
// bake walks the window with one source memory read a cycle and two reads per
// loop entry. tick uses one bit-serial divider, which is shared by the envelope
// volume division (31 steps) and the play pointer reduction (PP_W steps).
// env_length and channel_count sit on the apb port; write them only while
// the block is idle. synchronous reset clears loop size, play pointer and
// envelope and restores register defaults; sample and loop memories keep
// their contents and must be written before they are read.
module grain_loop_bake_and_envelope_player #(
   parameter int SOURCE_DEPTH = 8192,
   parameter int LOOP_DEPTH   = 4096,
   parameter int SAMPLE_BITS  = 16
) (
   input  logic                                   clock,
   input  logic                                   reset,

   input  logic                                   start,
   output logic                                   busy,
   input  logic [1:0]                             req_cmd,
   input  logic signed [glep_pkg::SVAL_W-1:0]     req_sample_value,
   input  logic [glep_pkg::SIDX_W-1:0]            req_sample_index,
   input  logic [glep_pkg::WST_W-1:0]             req_window_start,
   input  logic [glep_pkg::WEND_W-1:0]            req_window_end,

   output logic                                   rsp_strobe,
   output logic signed [glep_pkg::AUDIO_W-1:0]    rsp_audio_out,
   output logic [glep_pkg::VOL_W-1:0]             rsp_volume_now,
   output logic [glep_pkg::LCNT_W-1:0]            rsp_loop_count,

   input  logic                                   psel,
   input  logic                                   penable,
   input  logic                                   pwrite,
   input  logic [glep_pkg::CSR_AW-1:0]            paddr,
   input  logic [31:0]                            pwdata,
   output logic [31:0]                            prdata,
   output logic                                   pready
);
   import glep_pkg::*;

   localparam int SRC_AW  = $clog2(SOURCE_DEPTH);
   localparam int SRC_IW  = (SRC_AW > 15) ? SRC_AW : 15;
   localparam int LOOP_AW = $clog2(LOOP_DEPTH);
   localparam int PP_W    = LOOP_AW + 1;
   localparam int XW      = (SAMPLE_BITS > SVAL_W) ? SAMPLE_BITS : SVAL_W;
   localparam int PR_W    = SAMPLE_BITS + VOL_W + 1;

   typedef enum logic [3:0] {
      S_IDLE,
      S_DONE,
      S_B_CHK,
      S_B_RD_A,
      S_B_RD_B,
      S_B_WR,
      S_T_ENV,
      S_T_ACT,
      S_T_READ,
      S_T_MUL,
      S_DIV
   } state_type;

   state_type                   state_ff;
   logic                        accept;

   // configuration
   logic [15:0]                 env_len_ff;
   logic [1:0]                  chan_ff;
   logic                        csr_wr;

   // player state
   logic [PP_W-1:0]             ls_ff;
   logic [PP_W-1:0]             ptr_ff;
   logic [POS_W-1:0]            pos_ff;
   logic                        active_ff;
   logic [VOL_W-1:0]            vol_ff;

   // bake walk
   logic [SPAN_W-1:0]           span_ff;
   logic [WEND_W-1:0]           half_ff;
   logic [WEND_W-1:0]           base_ff;
   logic [SPAN_W-1:0]           a_ff;
   logic [PP_W-1:0]             n_ff;
   logic signed [SAMPLE_BITS-1:0] here_ff;

   // shared divider
   logic [DVD_W-1:0]            dvd_ff;
   logic [DVS_W-1:0]            dvs_ff;
   logic [DVS_W-1:0]            rem_ff;
   logic [CNT_W-1:0]            cnt_ff;
   logic                        div_vol_ff;
   logic [DVS_W:0]              trial;
   logic                        trial_ge;
   logic [DVS_W:0]              trial_sub;

   logic signed [PR_W-1:0]      prod_ff;
   logic signed [PR_W-1:0]      prod_sh;

   // result word
   logic                        rsp_strobe_ff;
   logic signed [AUDIO_W-1:0]   rsp_audio_ff;
   logic [VOL_W-1:0]            rsp_vol_ff;
   logic [LCNT_W-1:0]           rsp_lcnt_ff;

   // memories
   logic signed [SAMPLE_BITS-1:0] src_mem [SOURCE_DEPTH];
   logic signed [SAMPLE_BITS-1:0] loop_mem [LOOP_DEPTH];
   logic signed [SAMPLE_BITS-1:0] src_rd_ff;
   logic signed [SAMPLE_BITS-1:0] loop_rd_ff;
   logic                        src_we;
   logic [SRC_AW-1:0]           src_wa;
   logic [SRC_AW-1:0]           src_ra;
   logic signed [SAMPLE_BITS-1:0] src_wd;
   logic                        loop_we;
   logic signed [SAMPLE_BITS-1:0] loop_wd;

   // address and data arithmetic
   logic [SRC_IW-1:0]           wr_idx_ext;
   logic [XW-1:0]               wr_val_ext;
   logic [SRC_IW-1:0]           here_full;
   logic [SPAN_W:0]             off_sum;
   logic [SPAN_W-1:0]           off;
   logic [SRC_IW-1:0]           opp_full;
   logic signed [SAMPLE_BITS:0] pair_sum;
   logic [1:0]                  stride;
   logic [15:0]                 len;
   logic [POS_W-1:0]            pos_new;
   logic [15:0]                 vol_diff;
   logic [WEND_W-1:0]           win_half;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);
   assign pready = 1'b1;
   assign csr_wr = psel && penable && pwrite && pready;

   always_comb begin
      unique case (paddr)
         ADDR_ENV_LENGTH:    prdata = {16'h0000, env_len_ff};
         ADDR_CHANNEL_COUNT: prdata = {30'h0, chan_ff};
         default:            prdata = 32'h0;
      endcase
   end

   assign stride   = (chan_ff == 2'd0) ? 2'd1 : chan_ff;
   assign len      = (env_len_ff == 16'd0) ? 16'd1 : env_len_ff;
   assign pos_new  = (pos_ff != POS_MAX) ? pos_ff + 1'b1 : pos_ff;
   assign vol_diff = len - pos_new[15:0];
   assign win_half = req_window_end - WEND_W'(req_window_start);

   assign wr_idx_ext = SRC_IW'(req_sample_index);
   assign wr_val_ext = XW'($unsigned(req_sample_value));
   assign src_we     = accept && (req_cmd == CMD_WRITE);
   assign src_wa     = wr_idx_ext[SRC_AW-1:0];
   assign src_wd     = wr_val_ext[SAMPLE_BITS-1:0];

   assign here_full = SRC_IW'(base_ff) + SRC_IW'(a_ff);
   assign off_sum   = (SPAN_W + 1)'(a_ff) + (SPAN_W + 1)'(half_ff);
   assign off       = (off_sum >= (SPAN_W + 1)'(span_ff)) ?
                      SPAN_W'(off_sum - (SPAN_W + 1)'(span_ff)) : SPAN_W'(off_sum);
   assign opp_full  = SRC_IW'(base_ff) + SRC_IW'(off);
   assign src_ra    = (state_ff == S_B_RD_A) ? here_full[SRC_AW-1:0]
                                             : opp_full[SRC_AW-1:0];

   assign pair_sum = {here_ff[SAMPLE_BITS-1], here_ff}
                   + {src_rd_ff[SAMPLE_BITS-1], src_rd_ff};
   assign loop_we  = (state_ff == S_B_WR);
   assign loop_wd  = pair_sum[SAMPLE_BITS:1];

   assign trial     = {rem_ff, dvd_ff[DVD_W-1]};
   assign trial_ge  = (trial >= {1'b0, dvs_ff});
   assign trial_sub = trial - {1'b0, dvs_ff};

   assign prod_sh = prod_ff >>> Q15_SH;

   always_ff @(posedge clock) begin
      if (src_we) begin
         src_mem[src_wa] <= src_wd;
      end
      src_rd_ff <= src_mem[src_ra];
   end

   always_ff @(posedge clock) begin
      if (loop_we) begin
         loop_mem[n_ff[LOOP_AW-1:0]] <= loop_wd;
      end
      loop_rd_ff <= loop_mem[ptr_ff[LOOP_AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_strobe_ff <= 1'b0;
         env_len_ff    <= ENV_LENGTH_RESET;
         chan_ff       <= CHANNEL_COUNT_RESET;
         ls_ff         <= '0;
         ptr_ff        <= '0;
         pos_ff        <= '0;
         active_ff     <= 1'b0;
         vol_ff        <= '0;
      end else begin
         rsp_strobe_ff <= 1'b0;

         if (csr_wr) begin
            if (paddr[2] == REG_ENV_LENGTH) begin
               env_len_ff <= pwdata[15:0];
            end else begin
               chan_ff <= pwdata[1:0];
            end
         end

         unique case (state_ff)
            S_IDLE: begin
               if (accept) begin
                  prod_ff <= '0;
                  unique case (req_cmd)
                     CMD_WRITE: begin
                        state_ff <= S_DONE;
                     end
                     CMD_BAKE: begin
                        base_ff <= {req_window_start, 1'b0};
                        a_ff    <= '0;
                        n_ff    <= '0;
                        if (req_window_end > WEND_W'(req_window_start)) begin
                           half_ff <= win_half;
                           span_ff <= {win_half, 1'b0};
                        end else begin
                           half_ff <= '0;
                           span_ff <= '0;
                        end
                        state_ff <= S_B_CHK;
                     end
                     CMD_TICK: begin
                        state_ff <= S_T_ENV;
                     end
                     CMD_RETRIG: begin
                        active_ff <= 1'b1;
                        pos_ff    <= '0;
                        state_ff  <= S_DONE;
                     end
                     default: begin
                        state_ff <= S_DONE;
                     end
                  endcase
               end
            end

            S_B_CHK: begin
               if ((a_ff < span_ff) && (n_ff < PP_W'(LOOP_DEPTH))) begin
                  state_ff <= S_B_RD_A;
               end else begin
                  ls_ff    <= n_ff;
                  state_ff <= S_DONE;
               end
            end

            S_B_RD_A: begin
               state_ff <= S_B_RD_B;
            end

            S_B_RD_B: begin
               here_ff  <= src_rd_ff;
               state_ff <= S_B_WR;
            end

            S_B_WR: begin
               a_ff     <= a_ff + SPAN_W'(stride);
               n_ff     <= n_ff + 1'b1;
               state_ff <= S_B_CHK;
            end

            S_T_ENV: begin
               if (active_ff) begin
                  pos_ff <= pos_new;
                  if (pos_new >= POS_W'(len)) begin
                     vol_ff   <= '0;
                     state_ff <= S_T_ACT;
                  end else begin
                     dvd_ff     <= {vol_diff, 16'h0000};
                     dvs_ff     <= len;
                     rem_ff     <= '0;
                     cnt_ff     <= CNT_W'(VOL_STEPS);
                     div_vol_ff <= 1'b1;
                     state_ff   <= S_DIV;
                  end
               end else begin
                  state_ff <= S_T_ACT;
               end
            end

            S_T_ACT: begin
               if (pos_ff > POS_W'(len)) begin
                  active_ff <= 1'b0;
               end
               if (ls_ff == '0) begin
                  ptr_ff   <= ptr_ff + 1'b1;
                  state_ff <= S_DONE;
               end else if (ptr_ff >= ls_ff) begin
                  dvd_ff     <= DVD_W'(ptr_ff) << (DVD_W - PP_W);
                  dvs_ff     <= DVS_W'(ls_ff);
                  rem_ff     <= '0;
                  cnt_ff     <= CNT_W'(PP_W);
                  div_vol_ff <= 1'b0;
                  state_ff   <= S_DIV;
               end else begin
                  state_ff <= S_T_READ;
               end
            end

            S_DIV: begin
               if (cnt_ff != '0) begin
                  dvd_ff <= {dvd_ff[DVD_W-2:0], trial_ge};
                  rem_ff <= trial_ge ? trial_sub[DVS_W-1:0] : trial[DVS_W-1:0];
                  cnt_ff <= cnt_ff - 1'b1;
               end else if (div_vol_ff) begin
                  vol_ff   <= dvd_ff[VOL_W-1:0];
                  state_ff <= S_T_ACT;
               end else begin
                  ptr_ff   <= rem_ff[PP_W-1:0];
                  state_ff <= S_T_READ;
               end
            end

            S_T_READ: begin
               ptr_ff   <= ptr_ff + 1'b1;
               state_ff <= S_T_MUL;
            end

            S_T_MUL: begin
               prod_ff  <= PR_W'(loop_rd_ff) * PR_W'($signed({1'b0, vol_ff}));
               state_ff <= S_DONE;
            end

            S_DONE: begin
               rsp_strobe_ff <= 1'b1;
               rsp_audio_ff  <= prod_sh[AUDIO_W-1:0];
               rsp_vol_ff    <= vol_ff;
               rsp_lcnt_ff   <= LCNT_W'(ls_ff);
               state_ff      <= S_IDLE;
            end

            default: begin
               state_ff <= S_IDLE;
            end
         endcase
      end
   end

   assign rsp_strobe     = rsp_strobe_ff;
   assign rsp_audio_out  = rsp_audio_ff;
   assign rsp_volume_now = rsp_vol_ff;
   assign rsp_loop_count = rsp_lcnt_ff;

endmodule

@@ tb/grain_loop_bake_and_envelope_player_tb.sv @@
module grain_loop_bake_and_envelope_player_tb;
   import glep_pkg::*;

   localparam int SRC_WORDS      = 8192;
   localparam int LOOP_WORDS     = 4096;
   localparam int FILL_WORDS     = 512;
   localparam int FILL_FRAMES    = 256;
   localparam int RAND_PER_PHASE = 200;
   localparam int NUM_PHASES     = 6;
   localparam int LIMIT_CYCLES   = 3000000;
   localparam int NUM_CUES       = 25;

   typedef struct packed {
      logic signed [AUDIO_W-1:0] audio;
      logic [VOL_W-1:0]          volume;
      logic [LCNT_W-1:0]         count;
   } player_word_type;

   typedef struct packed {
      logic [1:0]        cmd;
      logic [SVAL_W-1:0] value;
      logic [SIDX_W-1:0] index;
      logic [WST_W-1:0]  wstart;
      logic [WEND_W-1:0] wend;
      logic              typed;
      player_word_type   want;
   } cue_type;

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       start = 1'b0;
   logic                       busy;
   logic [1:0]                 req_cmd = CMD_WRITE;
   logic signed [SVAL_W-1:0]   req_sample_value = '0;
   logic [SIDX_W-1:0]          req_sample_index = '0;
   logic [WST_W-1:0]           req_window_start = '0;
   logic [WEND_W-1:0]          req_window_end = '0;
   logic                       rsp_strobe;
   logic signed [AUDIO_W-1:0]  rsp_audio_out;
   logic [VOL_W-1:0]           rsp_volume_now;
   logic [LCNT_W-1:0]          rsp_loop_count;
   logic                       psel = 1'b0;
   logic                       penable = 1'b0;
   logic                       pwrite = 1'b0;
   logic [CSR_AW-1:0]          paddr = '0;
   logic [31:0]                pwdata = '0;
   logic [31:0]                prdata;
   logic                       pready;

   // player state as predicted
   logic signed [SVAL_W-1:0]   src_mem [SRC_WORDS];
   logic signed [SVAL_W-1:0]   loop_mem [LOOP_WORDS];
   int unsigned                loop_len = 0;
   int unsigned                play_ptr = 0;
   int unsigned                env_pos = 0;
   bit                         env_on = 1'b0;
   int unsigned                vol = 0;
   int unsigned                cfg_len = ENV_LENGTH_RESET;
   int unsigned                cfg_chans = CHANNEL_COUNT_RESET;

   player_word_type            owed_words [$];
   player_word_type            head_word;
   int                         mismatches = 0;
   int                         cycle_count = 0;
   int                         calm_left = 0;
   int unsigned                len_set [NUM_PHASES];
   int unsigned                chan_set [NUM_PHASES];

   cue_type cues [NUM_CUES] = '{
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_WRITE,  16'h7fff, 13'd0,    12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_WRITE,  16'h7fff, 13'd1,    12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_WRITE,  16'h8000, 13'd8191, 12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_WRITE,  16'h8000, 13'd8190, 12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_WRITE,  16'hffff, 13'd2,    12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_BAKE,   16'h0000, 13'd0,    12'd10,   13'd10,   1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_BAKE,   16'h0000, 13'd0,    12'd4095, 13'd0,    1'b1, '{16'sd0, 16'd0, 13'd0}},
      '{CMD_BAKE,   16'h0000, 13'd0,    12'd0,    13'd256,  1'b1, '{16'sd0, 16'd0, 13'd256}},
      '{CMD_BAKE,   16'h0000, 13'd0,    12'd4095, 13'd4096, 1'b1, '{16'sd0, 16'd0, 13'd1}},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd1}},
      '{CMD_RETRIG, 16'h0000, 13'd0,    12'd0,    13'd0,    1'b1, '{16'sd0, 16'd0, 13'd1}},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_BAKE,   16'h0000, 13'd0,    12'd0,    13'd1,    1'b0, '0},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_BAKE,   16'h0000, 13'd0,    12'd0,    13'd2,    1'b0, '0},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_RETRIG, 16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0},
      '{CMD_WRITE,  16'h3039, 13'd402,  12'd0,    13'd0,    1'b0, '0},
      '{CMD_BAKE,   16'h0000, 13'd0,    12'd200,  13'd204,  1'b0, '0},
      '{CMD_TICK,   16'h0000, 13'd0,    12'd0,    13'd0,    1'b0, '0}
   };

   grain_loop_bake_and_envelope_player u_top (
      .clock            (clock),
      .reset            (reset),
      .start            (start),
      .busy             (busy),
      .req_cmd          (req_cmd),
      .req_sample_value (req_sample_value),
      .req_sample_index (req_sample_index),
      .req_window_start (req_window_start),
      .req_window_end   (req_window_end),
      .rsp_strobe       (rsp_strobe),
      .rsp_audio_out    (rsp_audio_out),
      .rsp_volume_now   (rsp_volume_now),
      .rsp_loop_count   (rsp_loop_count),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= LIMIT_CYCLES) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   function automatic player_word_type play_step(input logic [1:0] cmd,
                                                 input logic signed [SVAL_W-1:0] value,
                                                 input logic [SIDX_W-1:0] index,
                                                 input logic [WST_W-1:0] ws,
                                                 input logic [WEND_W-1:0] we);
      player_word_type w;
      int unsigned  stride, span, base, a, off, len, s, e;
      int           here, opp;
      longint       entry, prod;
      w = '0;
      case (cmd)
         CMD_WRITE: begin
            src_mem[index] = value;
         end
         CMD_BAKE: begin
            s = ws;
            e = we;
            stride = (cfg_chans == 0) ? 1 : cfg_chans;
            span = (e > s) ? (e - s) * 2 : 0;
            base = s * 2;
            loop_len = 0;
            for (a = 0; a < span && loop_len < LOOP_WORDS; a += stride) begin
               here = src_mem[(base + a) % SRC_WORDS];
               off = (a + span / 2) % span;
               opp = src_mem[(base + off) % SRC_WORDS];
               loop_mem[loop_len] = SVAL_W'((here + opp) >>> 1);
               loop_len++;
            end
         end
         CMD_TICK: begin
            len = (cfg_len == 0) ? 1 : cfg_len;
            entry = 0;
            if (env_on) begin
               if (env_pos < POS_MAX)
                  env_pos++;
               if (env_pos >= len)
                  vol = 0;
               else
                  vol = int'((longint'(len - env_pos) * 64'sd32768) / longint'(len));
            end
            if (env_pos > len)
               env_on = 1'b0;
            if (loop_len > 0) begin
               play_ptr = play_ptr % loop_len;
               entry = loop_mem[play_ptr];
               play_ptr++;
            end else begin
               play_ptr = (play_ptr + 1) % (2 * LOOP_WORDS);
            end
            prod = entry * longint'(vol);
            w.audio = AUDIO_W'(prod >>> Q15_SH);
         end
         default: begin
            env_on = 1'b1;
            env_pos = 0;
         end
      endcase
      w.volume = VOL_W'(vol);
      w.count = LCNT_W'(loop_len);
      return w;
   endfunction

   function automatic logic [SVAL_W-1:0] pick_sample();
      int r;
      r = $urandom_range(0, 19);
      case (r)
         0: return 16'h7fff;
         1: return 16'h8000;
         2: return 16'h0000;
         3: return 16'hffff;
         default: return SVAL_W'($urandom);
      endcase
   endfunction

   function automatic int next_gap();
      int r;
      if (calm_left > 0) begin
         calm_left--;
         return 0;
      end
      r = $urandom_range(0, 99);
      if (r < 2) begin
         calm_left = $urandom_range(20, 80);
         return 0;
      end
      if (r < 50)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(6, 40);
   endfunction

   task automatic issue_word(input logic [1:0] cmd, input logic [SVAL_W-1:0] value,
                             input logic [SIDX_W-1:0] index, input logic [WST_W-1:0] ws,
                             input logic [WEND_W-1:0] we, input logic typed,
                             input player_word_type want);
      player_word_type got;
      int           gap;
      @(negedge clock);
      start = 1'b1;
      req_cmd = cmd;
      req_sample_value = value;
      req_sample_index = index;
      req_window_start = ws;
      req_window_end = we;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      got = play_step(cmd, value, index, ws, we);
      owed_words.insert(owed_words.size(), typed ? want : got);
      gap = next_gap();
      if (gap > 0) begin
         @(negedge clock);
         start = 1'b0;
         repeat (gap - 1)
            @(negedge clock);
      end
   endtask

   task automatic random_run(input int count);
      int               r, width;
      logic [1:0]       cmd;
      logic [SVAL_W-1:0] value;
      logic [SIDX_W-1:0] index;
      logic [WST_W-1:0]  ws;
      logic [WEND_W-1:0] we;
      for (int i = 0; i < count; i++) begin
         r = $urandom_range(0, 99);
         value = SVAL_W'($urandom);
         index = SIDX_W'($urandom);
         ws = WST_W'($urandom_range(0, FILL_FRAMES - 1));
         we = WEND_W'($urandom_range(0, 4096));
         if (r < 20) begin
            cmd = CMD_WRITE;
            value = pick_sample();
            if ($urandom_range(0, 3) != 0)
               index = SIDX_W'($urandom_range(0, FILL_WORDS - 1));
         end else if (r < 30) begin
            cmd = CMD_BAKE;
            r = $urandom_range(0, 99);
            if (r < 3) begin
               we = WEND_W'(FILL_FRAMES);
            end else if (r < 12) begin
               we = WEND_W'($urandom_range(0, ws));
            end else begin
               width = $urandom_range(1, 48);
               we = (int'(ws) + width > FILL_FRAMES) ? WEND_W'(FILL_FRAMES)
                                                     : WEND_W'(int'(ws) + width);
            end
         end else if (r < 90) begin
            cmd = CMD_TICK;
         end else begin
            cmd = CMD_RETRIG;
         end
         issue_word(cmd, value, index, ws, we, 1'b0, '0);
      end
   endtask

   task automatic settle();
      @(negedge clock);
      start = 1'b0;
      while (owed_words.size() != 0)
         @(posedge clock);
      repeat (40)
         @(posedge clock);
   endtask

   task automatic csr_set(input logic [CSR_AW-1:0] addr, input logic [31:0] data);
      logic [31:0] readback, want;
      @(negedge clock);
      psel = 1'b1;
      pwrite = 1'b1;
      penable = 1'b0;
      paddr = addr;
      pwdata = data;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      if (addr == ADDR_ENV_LENGTH) begin
         cfg_len = data[15:0];
         want = {16'd0, data[15:0]};
      end else begin
         cfg_chans = data[1:0];
         want = {30'd0, data[1:0]};
      end
      @(negedge clock);
      pwrite = 1'b0;
      penable = 1'b0;
      @(negedge clock);
      penable = 1'b1;
      @(posedge clock);
      while (!pready)
         @(posedge clock);
      readback = prdata;
      @(negedge clock);
      psel = 1'b0;
      penable = 1'b0;
      if (readback !== want) begin
         $display("%0t register %0h readback: expected %0h, got %0h",
                  $time, addr, want, readback);
         mismatches++;
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_strobe) begin
         if (owed_words.size() == 0) begin
            $display("%0t word with none expected: audio %0d volume %0d count %0d",
                     $time, rsp_audio_out, rsp_volume_now, rsp_loop_count);
            mismatches++;
         end else begin
            head_word = owed_words.pop_front();
            if (head_word.audio !== rsp_audio_out) begin
               $display("%0t audio_out: expected %0d, got %0d",
                        $time, head_word.audio, rsp_audio_out);
               mismatches++;
            end
            if (head_word.volume !== rsp_volume_now) begin
               $display("%0t volume_now: expected %0d, got %0d",
                        $time, head_word.volume, rsp_volume_now);
               mismatches++;
            end
            if (head_word.count !== rsp_loop_count) begin
               $display("%0t loop_count: expected %0d, got %0d",
                        $time, head_word.count, rsp_loop_count);
               mismatches++;
            end
         end
      end
   end

   initial begin
      len_set = '{1, 0, 65535, 13, $urandom_range(2, 300), $urandom_range(1, 65535)};
      chan_set = '{1, 0, 3, 2, $urandom_range(0, 3), $urandom_range(0, 3)};
      repeat (6)
         @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // fill the low part of the sample memory; the random bake windows stay inside it
      for (int a = 0; a < FILL_WORDS; a++)
         issue_word(CMD_WRITE, pick_sample(), SIDX_W'(a), WST_W'($urandom),
                    WEND_W'($urandom_range(0, 4096)), 1'b0, '0);

      for (int k = 0; k < NUM_CUES; k++)
         issue_word(cues[k].cmd, cues[k].value, cues[k].index, cues[k].wstart,
                    cues[k].wend, cues[k].typed, cues[k].want);
      random_run(RAND_PER_PHASE);

      for (int p = 0; p < NUM_PHASES; p++) begin
         settle();
         csr_set(ADDR_ENV_LENGTH, len_set[p]);
         csr_set(ADDR_CHANNEL_COUNT, chan_set[p]);
         issue_word(CMD_BAKE, SVAL_W'($urandom), SIDX_W'($urandom),
                    WST_W'($urandom_range(0, 63)), WEND_W'(FILL_FRAMES), 1'b0, '0);
         random_run(RAND_PER_PHASE);
      end

      settle();
      if (mismatches == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
